// File: rtl/core/utf8_strict_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 strict decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef UTF8_STRICT_DECODER_TOP_MACROS_SVH
`define UTF8_STRICT_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define U8SD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8sd assertion failed");

// next-cycle implication
`define U8SD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8sd assertion failed");

`endif

// File: rtl/core/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types and constants shared by the UTF-8 strict decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned CP_W        = 21;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned ERR_POS_W   = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_LEAD  = 3'd1,
    ST_TRUNC = 3'd2,
    ST_CONT  = 3'd3,
    ST_CP    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CLS_ASCII    = 3'd0,
    CLS_LEAD2    = 3'd1,
    CLS_LEAD3    = 3'd2,
    CLS_LEAD4    = 3'd3,
    CLS_BAD_LEAD = 3'd4
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    byte_class_t cls;
    logic        cont_ok;
  } byte_req_t;

  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_2BYTE  = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3BYTE  = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4BYTE  = 21'h010000;

  function automatic byte_class_t classify(input logic [7:0] b);
    byte_class_t c;
    if (b <= 8'h7F) begin
      c = CLS_ASCII;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      c = CLS_LEAD2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      c = CLS_LEAD3;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      c = CLS_LEAD4;
    end else begin
      c = CLS_BAD_LEAD;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/u8sd_ifs.sv
// ----------------------------------------------------------------------------
// u8sd interfaces
// Valid/ready channels for input bytes and decoded results.
// ----------------------------------------------------------------------------
interface u8sd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8sd_result_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  status;
  logic [15:0] error_position;
  logic        string_end;

  modport source (output valid, output code_point, output status,
                  output error_position, output string_end, input ready);
  modport sink (input valid, input code_point, input status,
                input error_position, input string_end, output ready);
endinterface

// File: rtl/core/utf8_strict_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_strict_decoder_top
// Strict UTF-8 decoder: one byte in per request, codepoint or error out.
//
//   channel     dir  payload
//   byte_in     in   data_byte[7:0], last_byte
//   result_out  out  code_point[20:0], status[2:0], error_position[15:0],
//                    string_end
//
// One byte per cycle sustained while the queue is not full; the sequence decoder steps once per byte.
// With an empty queue, a byte passes through a queue entry and then the output register.
// Four-entry queue lets the input keep flowing while result_out stalls.
// rst clears the offset counter, queue, sequence state and output valid flag.
// ----------------------------------------------------------------------------
module utf8_strict_decoder_top import u8sd_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  u8sd_byte_if.sink     byte_in,
  u8sd_result_if.source result_out
);

  localparam int unsigned ENTRY_W = POSITION_BITS + $bits(byte_req_t);

  logic                     q_push;
  logic                     q_pop;
  logic                     q_full;
  logic                     q_not_empty;
  byte_req_t                front_req;
  logic [POSITION_BITS-1:0] front_pos;
  byte_req_t                back_req;
  logic [POSITION_BITS-1:0] back_pos;
  logic [ENTRY_W-1:0]       q_rdata;

  u8sd_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_req   (front_req),
    .q_pos   (front_pos)
  );

  u8sd_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     ({front_pos, front_req}),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign back_req = q_rdata[$bits(byte_req_t)-1:0];
  assign back_pos = q_rdata[ENTRY_W-1:$bits(byte_req_t)];

  u8sd_back #(.POSITION_BITS(POSITION_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_not_empty),
    .q_req      (back_req),
    .q_pos      (back_pos),
    .q_pop      (q_pop),
    .result_out (result_out)
  );

endmodule

// File: rtl/core/u8sd_front.sv
// ----------------------------------------------------------------------------
// u8sd_front
// Accepts bytes, classifies them and stamps each with its string offset.
// ----------------------------------------------------------------------------
module u8sd_front import u8sd_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  u8sd_byte_if.sink                byte_in,
  input  logic                     q_full,
  output logic                     q_push,
  output byte_req_t                q_req,
  output logic [POSITION_BITS-1:0] q_pos
);

  logic [POSITION_BITS-1:0] byte_counter;
  logic [POSITION_BITS-1:0] byte_counter_next;

  assign byte_in.ready = !q_full;
  assign q_push        = byte_in.valid && !q_full;

  always_comb begin
    q_req.data    = byte_in.data_byte;
    q_req.last    = byte_in.last_byte;
    q_req.cls     = classify(byte_in.data_byte);
    q_req.cont_ok = (byte_in.data_byte[7:6] == 2'b10);
    q_pos         = byte_counter;
  end

  always_comb begin
    byte_counter_next = byte_counter;
    if (q_push) begin
      if (byte_in.last_byte) begin
        byte_counter_next = '0;
      end else if (byte_counter != '1) begin
        byte_counter_next = byte_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter <= '0;
    end else begin
      byte_counter <= byte_counter_next;
    end
  end

endmodule

// File: rtl/core/u8sd_queue.sv
// ----------------------------------------------------------------------------
// u8sd_queue
// Small register FIFO between the classifier and the sequence decoder.
// ----------------------------------------------------------------------------
module u8sd_queue import u8sd_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             not_empty
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/u8sd_back.sv
// ----------------------------------------------------------------------------
// u8sd_back
// Assembles sequences, checks them and registers one result per completed sequence or error.
// ----------------------------------------------------------------------------
module u8sd_back import u8sd_pkg::*; #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  byte_req_t                q_req,
  input  logic [POSITION_BITS-1:0] q_pos,
  output logic                     q_pop,
  u8sd_result_if.source            result_out
);

  localparam int unsigned EXT_W = (POSITION_BITS > ERR_POS_W) ? POSITION_BITS : ERR_POS_W;

  logic [1:0]               bytes_needed;
  logic [1:0]               bytes_seen;
  logic [CP_W-1:0]          partial_value;
  logic [POSITION_BITS-1:0] sequence_start;
  logic                     discarding;
  logic                     bad_pending;
  logic [POSITION_BITS-1:0] bad_offset;

  logic [1:0]               bytes_needed_next;
  logic [1:0]               bytes_seen_next;
  logic [CP_W-1:0]          partial_value_next;
  logic [POSITION_BITS-1:0] sequence_start_next;
  logic                     discarding_next;
  logic                     bad_pending_next;
  logic [POSITION_BITS-1:0] bad_offset_next;

  logic                     out_valid;
  logic [CP_W-1:0]          out_cp;
  status_t                  out_status;
  logic [ERR_POS_W-1:0]     out_pos;
  logic                     out_end;

  logic                     do_step;
  logic                     has_res;
  logic                     fail;
  status_t                  res_status;
  logic [CP_W-1:0]          res_cp;
  logic [POSITION_BITS-1:0] res_pos;
  logic [ERR_POS_W-1:0]     res_pos_clamped;
  logic [1:0]               seen_inc;
  logic [CP_W-1:0]          cp_shift;
  logic [CP_W-1:0]          cp_min;
  logic [EXT_W-1:0]         pos_ext;

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign do_step = q_valid && (!out_valid || result_out.ready);
  assign q_pop   = do_step;

  assign seen_inc = bytes_seen + 2'd1;
  assign cp_shift = {partial_value[CP_W-7:0], q_req.data[5:0]};

  always_comb begin
    case (bytes_needed)
      2'd1:    cp_min = MIN_2BYTE;
      2'd2:    cp_min = MIN_3BYTE;
      default: cp_min = MIN_4BYTE;
    endcase
  end

  always_comb begin
    bytes_needed_next   = bytes_needed;
    bytes_seen_next     = bytes_seen;
    partial_value_next  = partial_value;
    sequence_start_next = sequence_start;
    discarding_next     = discarding;
    bad_pending_next    = bad_pending;
    bad_offset_next     = bad_offset;
    has_res             = 1'b0;
    fail                = 1'b0;
    res_status          = ST_OK;
    res_cp              = '0;
    res_pos             = '0;

    if (discarding) begin
      has_res = 1'b0;
    end else if (bytes_needed == 2'd0) begin
      sequence_start_next = q_pos;
      bytes_seen_next     = 2'd0;
      bad_pending_next    = 1'b0;
      case (q_req.cls)
        CLS_ASCII: begin
          has_res = 1'b1;
          res_cp  = CP_W'(q_req.data);
        end
        CLS_LEAD2: begin
          bytes_needed_next  = 2'd1;
          partial_value_next = CP_W'(q_req.data[4:0]);
        end
        CLS_LEAD3: begin
          bytes_needed_next  = 2'd2;
          partial_value_next = CP_W'(q_req.data[3:0]);
        end
        CLS_LEAD4: begin
          bytes_needed_next  = 2'd3;
          partial_value_next = CP_W'(q_req.data[2:0]);
        end
        default: begin
          has_res    = 1'b1;
          fail       = 1'b1;
          res_status = ST_LEAD;
          res_pos    = q_pos;
        end
      endcase
      if (q_req.cls != CLS_ASCII && q_req.cls != CLS_BAD_LEAD && q_req.last) begin
        has_res    = 1'b1;
        fail       = 1'b1;
        res_status = ST_TRUNC;
        res_pos    = sat_inc(q_pos);
      end
    end else begin
      bytes_seen_next    = seen_inc;
      partial_value_next = cp_shift;
      if (!q_req.cont_ok && !bad_pending) begin
        bad_pending_next = 1'b1;
        bad_offset_next  = q_pos;
      end
      if (seen_inc >= bytes_needed) begin
        has_res = 1'b1;
        if (bad_pending_next) begin
          fail       = 1'b1;
          res_status = ST_CONT;
          res_pos    = bad_offset_next;
        end else if (cp_shift < cp_min || cp_shift > CP_MAX ||
                     (cp_shift >= SURR_LO && cp_shift <= SURR_HI)) begin
          fail       = 1'b1;
          res_status = ST_CP;
          res_pos    = sequence_start;
        end else begin
          res_cp = cp_shift;
        end
        bytes_needed_next  = 2'd0;
        bytes_seen_next    = 2'd0;
        bad_pending_next   = 1'b0;
        partial_value_next = '0;
      end else if (q_req.last) begin
        has_res    = 1'b1;
        fail       = 1'b1;
        res_status = ST_TRUNC;
        res_pos    = sat_inc(sequence_start);
      end
    end

    if (q_req.last) begin
      bytes_needed_next   = 2'd0;
      bytes_seen_next     = 2'd0;
      partial_value_next  = '0;
      sequence_start_next = '0;
      discarding_next     = 1'b0;
      bad_pending_next    = 1'b0;
      bad_offset_next     = '0;
    end else if (fail) begin
      discarding_next    = 1'b1;
      bytes_needed_next  = 2'd0;
      bytes_seen_next    = 2'd0;
      bad_pending_next   = 1'b0;
      partial_value_next = '0;
    end
  end

  // clamp reported offset to the 16-bit field
  always_comb begin
    pos_ext = EXT_W'(res_pos);
    if (pos_ext > EXT_W'(16'hFFFF)) begin
      res_pos_clamped = '1;
    end else begin
      res_pos_clamped = pos_ext[ERR_POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_needed   <= 2'd0;
      bytes_seen     <= 2'd0;
      partial_value  <= '0;
      sequence_start <= '0;
      discarding     <= 1'b0;
      bad_pending    <= 1'b0;
      bad_offset     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (do_step) begin
        bytes_needed   <= bytes_needed_next;
        bytes_seen     <= bytes_seen_next;
        partial_value  <= partial_value_next;
        sequence_start <= sequence_start_next;
        discarding     <= discarding_next;
        bad_pending    <= bad_pending_next;
        bad_offset     <= bad_offset_next;
        out_valid      <= has_res;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_step && has_res) begin
      out_cp     <= res_cp;
      out_status <= res_status;
      out_pos    <= res_pos_clamped;
      out_end    <= q_req.last;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.code_point     = out_cp;
  assign result_out.status         = out_status;
  assign result_out.error_position = out_pos;
  assign result_out.string_end     = out_end;

  `include "utf8_strict_decoder_top_macros.svh"

  `U8SD_ASSERT_IMP(a_err_zero_cp, out_valid && out_status != ST_OK, out_cp == '0)
  `U8SD_ASSERT_IMP(a_ok_zero_pos, out_valid && out_status == ST_OK, out_pos == '0)
  `U8SD_ASSERT_NXT(a_last_clears, do_step && q_req.last, bytes_needed == 2'd0 && !discarding)
  `U8SD_ASSERT_IMP(a_idle_no_seen, bytes_needed == 2'd0, bytes_seen == 2'd0 && !bad_pending)
  `U8SD_ASSERT_IMP(a_discard_idle, discarding, bytes_needed == 2'd0)

endmodule
